// ----- rtl/core/aliquot_sum_classifier_defines.svh -----
// Assertion macros for aliquot_sum_classifier.sv, the one file that asserts.
`ifndef ALIQUOT_SUM_CLASSIFIER_DEFINES_SVH
`define ALIQUOT_SUM_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define ASC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("aliquot_sum_classifier: same-cycle check failed");

// Next-cycle implication.
`define ASC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("aliquot_sum_classifier: next-cycle check failed");

`endif

// ----- rtl/core/asc_pkg.sv -----
package asc_pkg;

	localparam int NUMBER_BITS = 16;
	localparam int SUM_BITS    = 18;
	// aliquot sum stays below 8*n for any n under 2^31
	localparam int ACC_W = (NUMBER_BITS + 3 > SUM_BITS) ? NUMBER_BITS + 3 : SUM_BITS;
	localparam int CNT_W = $clog2(NUMBER_BITS);

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic div_init;
		logic div_step;
		logic accum;
		logic save_a;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic cand_done;
		logic bit_last;
		logic amic_go;
	} sts_t;

endpackage

// ----- rtl/core/asc_datapath.sv -----
module asc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [asc_pkg::NUMBER_BITS-1:0]  num_a,
	input  logic [asc_pkg::NUMBER_BITS-1:0]  num_b,
	input  asc_pkg::cmd_t                    cmd,
	output asc_pkg::sts_t                    sts,
	output logic [asc_pkg::SUM_BITS-1:0]     divisor_sum_a,
	output logic                             is_perfect,
	output logic                             is_deficient,
	output logic                             is_amicable,
	output logic                             done
);
	import asc_pkg::*;

	logic [NUMBER_BITS-1:0] a_q, b_q, n_q, d_q, rem_q;
	logic [CNT_W-1:0]       bit_q;
	logic [ACC_W-1:0]       sum_q, sum_a_q;
	logic                   ran_b_q;
	logic [NUMBER_BITS:0]   trial;
	logic [NUMBER_BITS:0]   trial_sub;
	logic [NUMBER_BITS-1:0] rem_next;
	logic [ACC_W-1:0]       a_ext;

	// one restoring division step per cycle, remainder only
	assign trial     = {rem_q, n_q[bit_q]};
	assign trial_sub = trial - {1'b0, d_q};
	assign rem_next  = (trial >= {1'b0, d_q}) ? trial_sub[NUMBER_BITS-1:0]
	                                          : trial[NUMBER_BITS-1:0];
	assign a_ext     = ACC_W'(a_q);

	assign sts.cand_done = (d_q >= n_q);
	assign sts.bit_last  = (bit_q == '0);
	assign sts.amic_go   = (a_q != '0) && (b_q != '0) && (sum_q == ACC_W'(b_q));

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			a_q     <= num_a;
			b_q     <= num_b;
			n_q     <= num_a;
			d_q     <= NUMBER_BITS'(2);
			sum_q   <= (num_a < NUMBER_BITS'(2)) ? '0 : ACC_W'(1);
		end else if (cmd.load_b) begin
			n_q     <= b_q;
			d_q     <= NUMBER_BITS'(2);
			sum_q   <= (b_q < NUMBER_BITS'(2)) ? '0 : ACC_W'(1);
		end else if (cmd.accum) begin
			if (rem_q == '0) begin
				sum_q <= sum_q + ACC_W'(d_q);
			end
			d_q <= d_q + NUMBER_BITS'(1);
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			bit_q <= CNT_W'(NUMBER_BITS - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			bit_q <= bit_q - CNT_W'(1);
		end
		if (cmd.save_a) begin
			sum_a_q <= sum_q;
		end
		if (cmd.finish) begin
			divisor_sum_a <= sum_a_q[SUM_BITS-1:0];
			is_perfect    <= (a_q != '0) && (sum_a_q == a_ext);
			is_deficient  <= (a_q != '0) && (sum_a_q < a_ext);
			is_amicable   <= ran_b_q && (sum_q == a_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ran_b_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			if (cmd.load_a) begin
				ran_b_q <= 1'b0;
			end else if (cmd.load_b) begin
				ran_b_q <= 1'b1;
			end
			done <= cmd.finish;
		end
	end

endmodule

// ----- rtl/core/asc_ctrl.sv -----
module asc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  asc_pkg::sts_t sts,
	output asc_pkg::cmd_t cmd,
	output logic          busy
);
	import asc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_ACC    = 3'd3;
	localparam logic [2:0] ST_END    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q, state_d;
	logic       phase_q, phase_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_a = 1'b1;
					phase_d    = 1'b0;
					state_d    = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (sts.cand_done) begin
					state_d = ST_END;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.bit_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = ST_SETUP;
			end
			ST_END: begin
				if (!phase_q) begin
					cmd.save_a = 1'b1;
					if (sts.amic_go) begin
						cmd.load_b = 1'b1;
						phase_d    = 1'b1;
						state_d    = ST_SETUP;
					end else begin
						state_d = ST_FINISH;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ----- rtl/core/aliquot_sum_classifier.sv -----
// channel   ports                                           handshake
// request   num_a, num_b                                    start & !busy
// result    divisor_sum_a, is_perfect, is_deficient,        done, one cycle
//           is_amicable
//
// One request at a time. Each candidate divisor 2..n-1 takes a setup state, NUMBER_BITS
// steps of the one-bit-per-cycle remainder unit and an accumulate state; the partner
// is run the same way only when the first sum equals it.
// arst_n clears the controller; done pulses for one cycle and cannot be held off.
`include "aliquot_sum_classifier_defines.svh"

module aliquot_sum_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [asc_pkg::NUMBER_BITS-1:0] num_a,
	input  logic [asc_pkg::NUMBER_BITS-1:0] num_b,
	output logic                            done,
	output logic [asc_pkg::SUM_BITS-1:0]    divisor_sum_a,
	output logic                            is_perfect,
	output logic                            is_deficient,
	output logic                            is_amicable
);
	import asc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	asc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	asc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_a         (num_a),
		.num_b         (num_b),
		.cmd           (cmd),
		.sts           (sts),
		.divisor_sum_a (divisor_sum_a),
		.is_perfect    (is_perfect),
		.is_deficient  (is_deficient),
		.is_amicable   (is_amicable),
		.done          (done)
	);

	`ASC_ASSERT_NOW(a_done_idle, done, !busy)
	`ASC_ASSERT_NEXT(a_req_busy, start && !busy, busy)
	`ASC_ASSERT_NEXT(a_done_pulse, done, !done)
	`ASC_ASSERT_NOW(a_flags_excl, done, !(is_perfect && is_deficient))

endmodule

// ----- tb/aliquot_sum_classifier_tb.sv -----
module aliquot_sum_classifier_tb;
	import asc_pkg::*;

	typedef struct {
		logic [NUMBER_BITS-1:0] a;
		logic [NUMBER_BITS-1:0] b;
		bit                     drain;
	} number_pair_t;

	typedef struct {
		logic [SUM_BITS-1:0] sum;
		logic                perfect;
		logic                deficient;
		logic                amicable;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [NUMBER_BITS-1:0] num_a = '0;
	logic [NUMBER_BITS-1:0] num_b = '0;
	logic                   busy;
	logic                   done;
	logic [SUM_BITS-1:0]    divisor_sum_a;
	logic                   is_perfect;
	logic                   is_deficient;
	logic                   is_amicable;

	number_pair_t pending_pairs[$];
	verdict_t     expected_verdicts[$];

	int  mismatches = 0;
	int  requests_sent = 0;
	int  verdicts_seen = 0;
	int  perfect_seen = 0;
	int  deficient_seen = 0;
	int  amicable_seen = 0;
	int  idle_left = 0;
	bit  wait_free = 1'b0;

	aliquot_sum_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.num_a        (num_a),
		.num_b        (num_b),
		.done         (done),
		.divisor_sum_a(divisor_sum_a),
		.is_perfect   (is_perfect),
		.is_deficient (is_deficient),
		.is_amicable  (is_amicable)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned proper_divisor_sum(input longint unsigned n);
		longint unsigned acc;
		longint unsigned d;
		if (n < 2) return 0;
		acc = 1;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0) begin
				acc += d;
				if (n / d != d) acc += n / d;
			end
		end
		return acc;
	endfunction

	function automatic verdict_t classify_pair(input logic [NUMBER_BITS-1:0] a,
			input logic [NUMBER_BITS-1:0] b);
		verdict_t        v;
		longint unsigned sa;
		sa = proper_divisor_sum(a);
		v.sum       = sa[SUM_BITS-1:0];
		v.perfect   = (a != 0) && (sa == a);
		v.deficient = (a != 0) && (sa < a);
		v.amicable  = (a != 0) && (b != 0) && (sa == b) && (proper_divisor_sum(b) == a);
		return v;
	endfunction

	task automatic add_pair(input int a, input int b, input bit drain);
		number_pair_t p;
		p.a     = a[NUMBER_BITS-1:0];
		p.b     = b[NUMBER_BITS-1:0];
		p.drain = drain;
		pending_pairs.push_back(p);
	endtask

	task automatic report_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		bit              fire;
		bit              nxt_start;
		number_pair_t    p;
		if (!arst_n) begin
			start <= 1'b0;
			num_a <= '0;
			num_b <= '0;
		end else begin
			fire      = start && !busy;
			nxt_start = start && !fire;
			if (fire) begin
				expected_verdicts.push_back(classify_pair(num_a, num_b));
				void'(pending_pairs.pop_front());
				requests_sent++;
				if (pending_pairs.size() > 20) begin
					case ($urandom_range(0, 2))
						1: idle_left = $urandom_range(1, 18);
						2: begin
							wait_free = 1'b1;
							idle_left = $urandom_range(1, 18);
						end
						default: idle_left = 0;
					endcase
				end
			end
			if (!nxt_start) begin
				if (wait_free) begin
					if (expected_verdicts.size() == 0) wait_free = 1'b0;
				end else if (idle_left > 0) begin
					idle_left--;
				end else if (pending_pairs.size() > 0 &&
						!(pending_pairs[0].drain && expected_verdicts.size() != 0)) begin
					p = pending_pairs[0];
					nxt_start = 1'b1;
					num_a <= p.a;
					num_b <= p.b;
				end
			end
			start <= nxt_start;
		end
	end

	// result monitor
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done === 1'b1) begin
			verdicts_seen++;
			if (is_perfect === 1'b1) perfect_seen++;
			if (is_deficient === 1'b1) deficient_seen++;
			if (is_amicable === 1'b1) amicable_seen++;
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result with no request outstanding: sum %0d", $realtime,
						divisor_sum_a);
			end else begin
				want = expected_verdicts.pop_front();
				if (divisor_sum_a !== want.sum)
					report_mismatch("divisor_sum_a", want.sum, divisor_sum_a);
				if (is_perfect !== want.perfect)
					report_mismatch("is_perfect", want.perfect, is_perfect);
				if (is_deficient !== want.deficient)
					report_mismatch("is_deficient", want.deficient, is_deficient);
				if (is_amicable !== want.amicable)
					report_mismatch("is_amicable", want.amicable, is_amicable);
			end
		end
	end

	initial begin
		#600_000_000;
		$display("aliquot_sum_classifier_tb: FAIL");
		$finish;
	end

	initial begin
		int amicable_a[9];
		int amicable_b[9];
		int a;
		int b;
		int k;

		amicable_a = '{6, 28, 496, 220, 284, 1184, 1210, 2620, 2924};
		amicable_b = '{6, 28, 496, 284, 220, 1210, 1184, 2924, 2620};

		// directed: zero, one, primes, perfect, amicable, near misses, extremes
		add_pair(0, 0, 1'b0);
		add_pair(0, 6, 1'b0);
		add_pair(6, 0, 1'b0);
		add_pair(1, 1, 1'b0);
		add_pair(1, 65535, 1'b0);
		add_pair(2, 1, 1'b0);
		add_pair(3, 3, 1'b0);
		add_pair(4, 3, 1'b0);
		add_pair(6, 6, 1'b0);
		add_pair(28, 28, 1'b1);
		add_pair(12, 16, 1'b0);
		add_pair(24, 36, 1'b0);
		add_pair(25, 6, 1'b0);
		add_pair(496, 496, 1'b0);
		add_pair(220, 284, 1'b0);
		add_pair(284, 220, 1'b0);
		add_pair(220, 220, 1'b0);
		add_pair(945, 975, 1'b0);
		add_pair(1184, 1210, 1'b1);
		add_pair(65535, 65535, 1'b0);
		add_pair(32768, 32767, 1'b0);

		// random: mostly small numbers; partner often set to the sum of the first
		for (int i = 0; i < 80; i++) begin
			k = $urandom_range(0, 99);
			if (k < 5) a = 0;
			else if (k < 85) a = $urandom_range(1, 300);
			else a = $urandom_range(301, 2048);
			k = $urandom_range(0, 99);
			if (k < 40) begin
				b = int'(proper_divisor_sum(a));
			end else if (k < 55) begin
				k = $urandom_range(0, 8);
				a = amicable_a[k];
				b = amicable_b[k];
			end else if (k < 60) begin
				b = 0;
			end else begin
				b = $urandom_range(0, 65535);
			end
			add_pair(a, b, $urandom_range(0, 19) == 0);
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_pairs.size() != 0 || start) @(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d requests classified, %0d results checked", requests_sent, verdicts_seen);
		$display("flags raised: %0d perfect, %0d deficient, %0d amicable; %0d mismatches",
			perfect_seen, deficient_seen, amicable_seen, mismatches);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("aliquot_sum_classifier_tb: PASS");
		else
			$display("aliquot_sum_classifier_tb: FAIL");
		$finish;
	end

endmodule
